// ===== design/dtc_pkg.sv =====
package dtc_pkg;

    localparam int MUL_W = 27;
    localparam int PROD_W = 54;
    localparam int QUO_W = 17;
    localparam int SOD_W = 17;
    localparam int TOTAL_W = 34;
    localparam int DAY_W = 17;
    localparam int YEAR_W = 16;
    localparam int YMOD_W = 9;

    // whole days added so the floor division works on a non-negative dividend
    localparam logic [DAY_W:0] BIAS_DAYS = 18'd24858;
    localparam logic [TOTAL_W-1:0] BIAS_SECS = 34'd2147731200;

    // 86400 = 675 * 128, the low 7 bits bypass the division
    localparam int DAY_LOW_W = 7;
    localparam logic [MUL_W-1:0] DAY_ODD = 27'd675;
    localparam logic [MUL_W-1:0] DAY_RECIP = 27'd101806633;
    localparam int DAY_SHIFT = 36;
    localparam logic [MUL_W-1:0] YEARS_PER_CYCLE = 27'd400;
    localparam logic [MUL_W-1:0] YEAR_RECIP = 27'd20972;
    localparam int YEAR_SHIFT = 23;
    localparam logic [MUL_W-1:0] SECS_PER_HOUR = 27'd3600;
    localparam logic [MUL_W-1:0] HOUR_RECIP = 27'd149131;
    localparam int HOUR_SHIFT = 29;
    localparam logic [MUL_W-1:0] SECS_PER_MIN = 27'd60;
    localparam logic [MUL_W-1:0] MIN_RECIP = 27'd4370;
    localparam int MIN_SHIFT = 18;

    localparam logic signed [YEAR_W-1:0] YEAR_MAX = 16'sd9999;
    localparam logic [YMOD_W-1:0] YMOD_LAST = 9'd399;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_Q,
        ST_DAY_R,
        ST_YEAR_Q,
        ST_YEAR_R,
        ST_ROLL,
        ST_MONTH,
        ST_HOUR_Q,
        ST_HOUR_R,
        ST_MIN_Q,
        ST_MIN_R,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    // leap test on the year taken modulo 400
    function automatic logic leap_of(input logic [YMOD_W-1:0] m);
        return (m[1:0] == 2'b00) && (m != 9'd100) && (m != 9'd200) && (m != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3,
            4'd5,
            4'd8,
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/dtc_divstep.sv =====
module dtc_divstep (
    input  dtc_pkg::mul_req_t req,
    output dtc_pkg::mul_rsp_t rsp
);

    // shared multiplier for reciprocal quotients and remainder products
    assign rsp.prod = {{dtc_pkg::MUL_W{1'b0}}, req.a} * {{dtc_pkg::MUL_W{1'b0}}, req.b};

endmodule

// ===== design/day_of_year_to_calendar_datetime.sv =====
// Converts year, day of year and signed UTC seconds, shifted by the time zone offset
// written on cfg_we, into calendar date and local time of day. The sequencer takes no
// new beat until it has moved the result into the output register. It steps through
// the floor division by 86400, the year modulo 400, the year roll, which moves one
// year at a time (up to about 70 years for a 32-bit second count), the month walk,
// which moves one month at a time (up to 11), and the hour and minute split; on a
// range error the month walk is skipped. The floor division by 86400, the year
// modulo 400 and the hour and minute split each use a single shared multiplier,
// first for a reciprocal quotient and then for the remainder. A finished result
// waits in the sequencer while the output register is full. in_ready is high
// whenever the sequencer is idle, also while a result waits in the output
// register.
module day_of_year_to_calendar_datetime (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic signed [10:0] tz_offset_minutes,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [13:0]        year,
    input  logic [8:0]         day_number,
    input  logic signed [31:0] utc_seconds,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [13:0]        out_year,
    output logic [3:0]         out_month,
    output logic [4:0]         out_day,
    output logic [4:0]         out_hour,
    output logic [5:0]         out_minute,
    output logic [5:0]         out_second,
    output logic               range_error
);

    dtc_pkg::state_t state_reg, state_next;

    logic signed [10:0] tz_reg;
    logic [dtc_pkg::MUL_W-1:0] num_reg, num_next;
    logic [dtc_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [dtc_pkg::DAY_LOW_W-1:0] low_reg, low_next;
    logic signed [dtc_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [dtc_pkg::YMOD_W-1:0] ymod_reg, ymod_next;
    logic signed [dtc_pkg::DAY_W-1:0] day_reg, day_next;
    logic [3:0] mon_reg, mon_next;
    logic err_reg, err_next;
    logic [dtc_pkg::SOD_W-1:0] sod_reg, sod_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] min_reg, min_next;

    logic out_valid_reg, out_valid_next;
    logic [13:0] out_year_reg, out_year_next;
    logic [3:0] out_month_reg, out_month_next;
    logic [4:0] out_day_reg, out_day_next;
    logic [4:0] out_hour_reg, out_hour_next;
    logic [5:0] out_minute_reg, out_minute_next;
    logic [5:0] out_second_reg, out_second_next;
    logic range_error_reg, range_error_next;

    dtc_pkg::mul_req_t mul_req;
    dtc_pkg::mul_rsp_t mul_rsp;

    logic [dtc_pkg::TOTAL_W-1:0] secs_ext, tz_ext, tz_secs, biased;
    logic [dtc_pkg::MUL_W-1:0] quo_ext, diff, sod_ext;
    logic [dtc_pkg::DAY_W:0] day_carry;
    logic [dtc_pkg::YMOD_W-1:0] ymod_prev, ymod_succ;
    logic [8:0] len_cur, len_prev;
    logic [4:0] mlen;
    logic year_bad;

    dtc_divstep u_divstep (
        .req (mul_req),
        .rsp (mul_rsp)
    );

    assign secs_ext = {{(dtc_pkg::TOTAL_W - 32){utc_seconds[31]}}, utc_seconds};
    assign tz_ext = {{(dtc_pkg::TOTAL_W - 11){tz_reg[10]}}, tz_reg};
    assign tz_secs = (tz_ext << 6) - (tz_ext << 2);
    assign biased = secs_ext + tz_secs + dtc_pkg::BIAS_SECS;

    assign quo_ext = {{(dtc_pkg::MUL_W - dtc_pkg::QUO_W){1'b0}}, quo_reg};
    assign sod_ext = {{(dtc_pkg::MUL_W - dtc_pkg::SOD_W){1'b0}}, sod_reg};
    assign diff = num_reg - mul_rsp.prod[dtc_pkg::MUL_W-1:0];
    assign day_carry = {day_reg[dtc_pkg::DAY_W-1], day_reg} + {1'b0, quo_reg}
                       - dtc_pkg::BIAS_DAYS;

    assign ymod_prev = (ymod_reg == '0) ? dtc_pkg::YMOD_LAST : ymod_reg - 9'd1;
    assign ymod_succ = (ymod_reg == dtc_pkg::YMOD_LAST) ? '0 : ymod_reg + 9'd1;
    assign len_cur = 9'd365 + {8'b0, dtc_pkg::leap_of(ymod_reg)};
    assign len_prev = 9'd365 + {8'b0, dtc_pkg::leap_of(ymod_prev)};
    assign mlen = dtc_pkg::month_len(mon_reg, dtc_pkg::leap_of(ymod_reg));
    assign year_bad = (year_reg < 0) || (year_reg > dtc_pkg::YEAR_MAX);

    always_comb
    begin
        mul_req.a = num_reg;
        mul_req.b = '0;
        case (state_reg)
            dtc_pkg::ST_DAY_Q:  mul_req.b = dtc_pkg::DAY_RECIP;
            dtc_pkg::ST_DAY_R:
            begin
                mul_req.a = quo_ext;
                mul_req.b = dtc_pkg::DAY_ODD;
            end
            dtc_pkg::ST_YEAR_Q: mul_req.b = dtc_pkg::YEAR_RECIP;
            dtc_pkg::ST_YEAR_R:
            begin
                mul_req.a = quo_ext;
                mul_req.b = dtc_pkg::YEARS_PER_CYCLE;
            end
            dtc_pkg::ST_HOUR_Q: mul_req.b = dtc_pkg::HOUR_RECIP;
            dtc_pkg::ST_HOUR_R:
            begin
                mul_req.a = quo_ext;
                mul_req.b = dtc_pkg::SECS_PER_HOUR;
            end
            dtc_pkg::ST_MIN_Q:  mul_req.b = dtc_pkg::MIN_RECIP;
            dtc_pkg::ST_MIN_R:
            begin
                mul_req.a = quo_ext;
                mul_req.b = dtc_pkg::SECS_PER_MIN;
            end
            default:            mul_req.b = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        low_next = low_reg;
        year_next = year_reg;
        ymod_next = ymod_reg;
        day_next = day_reg;
        mon_next = mon_reg;
        err_next = err_reg;
        sod_next = sod_reg;
        hour_next = hour_reg;
        min_next = min_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_year_next = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next = out_day_reg;
        out_hour_next = out_hour_reg;
        out_minute_next = out_minute_reg;
        out_second_next = out_second_reg;
        range_error_next = range_error_reg;
        in_ready = 1'b0;

        case (state_reg)
            dtc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    num_next = {1'b0, biased[dtc_pkg::TOTAL_W-2:dtc_pkg::DAY_LOW_W]};
                    low_next = biased[dtc_pkg::DAY_LOW_W-1:0];
                    year_next = {2'b00, year};
                    day_next = {8'b0, day_number};
                    state_next = dtc_pkg::ST_DAY_Q;
                end
            end
            dtc_pkg::ST_DAY_Q:
            begin
                quo_next = mul_rsp.prod[dtc_pkg::DAY_SHIFT +: dtc_pkg::QUO_W];
                state_next = dtc_pkg::ST_DAY_R;
            end
            dtc_pkg::ST_DAY_R:
            begin
                sod_next = {diff[9:0], low_reg};
                day_next = day_carry[dtc_pkg::DAY_W-1:0];
                num_next = {{(dtc_pkg::MUL_W - 14){1'b0}}, year_reg[13:0]};
                state_next = dtc_pkg::ST_YEAR_Q;
            end
            dtc_pkg::ST_YEAR_Q:
            begin
                quo_next = {{(dtc_pkg::QUO_W - 6){1'b0}},
                            mul_rsp.prod[dtc_pkg::YEAR_SHIFT +: 6]};
                state_next = dtc_pkg::ST_YEAR_R;
            end
            dtc_pkg::ST_YEAR_R:
            begin
                ymod_next = diff[dtc_pkg::YMOD_W-1:0];
                state_next = dtc_pkg::ST_ROLL;
            end
            dtc_pkg::ST_ROLL:
            begin
                if (day_reg > 0 && day_reg <= $signed({8'b0, len_cur}))
                begin
                    err_next = year_bad;
                    mon_next = '0;
                    if (year_bad)
                    begin
                        num_next = sod_ext;
                        state_next = dtc_pkg::ST_HOUR_Q;
                    end
                    else
                    begin
                        state_next = dtc_pkg::ST_MONTH;
                    end
                end
                else if (day_reg <= 0)
                begin
                    year_next = year_reg - 16'sd1;
                    ymod_next = ymod_prev;
                    day_next = day_reg + $signed({8'b0, len_prev});
                end
                else
                begin
                    year_next = year_reg + 16'sd1;
                    ymod_next = ymod_succ;
                    day_next = day_reg - $signed({8'b0, len_cur});
                end
            end
            dtc_pkg::ST_MONTH:
            begin
                if (mon_reg >= dtc_pkg::MONTH_DEC || day_reg <= $signed({12'b0, mlen}))
                begin
                    num_next = sod_ext;
                    state_next = dtc_pkg::ST_HOUR_Q;
                end
                else
                begin
                    day_next = day_reg - $signed({12'b0, mlen});
                    mon_next = mon_reg + 4'd1;
                end
            end
            dtc_pkg::ST_HOUR_Q:
            begin
                quo_next = {{(dtc_pkg::QUO_W - 5){1'b0}},
                            mul_rsp.prod[dtc_pkg::HOUR_SHIFT +: 5]};
                state_next = dtc_pkg::ST_HOUR_R;
            end
            dtc_pkg::ST_HOUR_R:
            begin
                hour_next = quo_reg[4:0];
                num_next = diff;
                state_next = dtc_pkg::ST_MIN_Q;
            end
            dtc_pkg::ST_MIN_Q:
            begin
                quo_next = {{(dtc_pkg::QUO_W - 6){1'b0}},
                            mul_rsp.prod[dtc_pkg::MIN_SHIFT +: 6]};
                state_next = dtc_pkg::ST_MIN_R;
            end
            dtc_pkg::ST_MIN_R:
            begin
                min_next = quo_reg[5:0];
                num_next = diff;
                state_next = dtc_pkg::ST_DONE;
            end
            dtc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_year_next = err_reg ? '0 : year_reg[13:0];
                    out_month_next = err_reg ? '0 : mon_reg + 4'd1;
                    out_day_next = err_reg ? '0 : day_reg[4:0];
                    out_hour_next = hour_reg;
                    out_minute_next = min_reg;
                    out_second_next = num_reg[5:0];
                    range_error_next = err_reg;
                    state_next = dtc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            tz_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tz_reg <= tz_offset_minutes;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        low_reg <= low_next;
        year_reg <= year_next;
        ymod_reg <= ymod_next;
        day_reg <= day_next;
        mon_reg <= mon_next;
        err_reg <= err_next;
        sod_reg <= sod_next;
        hour_reg <= hour_next;
        min_reg <= min_next;
        out_year_reg <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg <= out_day_next;
        out_hour_reg <= out_hour_next;
        out_minute_reg <= out_minute_next;
        out_second_reg <= out_second_next;
        range_error_reg <= range_error_next;
    end

    assign out_valid = out_valid_reg;
    assign out_year = out_year_reg;
    assign out_month = out_month_reg;
    assign out_day = out_day_reg;
    assign out_hour = out_hour_reg;
    assign out_minute = out_minute_reg;
    assign out_second = out_second_reg;
    assign range_error = range_error_reg;

endmodule

// ===== design/dtc_checker.sv =====
module dtc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_we,
    input logic signed [10:0] tz_offset_minutes,
    input logic               in_valid,
    input logic               in_ready,
    input logic [13:0]        year,
    input logic [8:0]         day_number,
    input logic signed [31:0] utc_seconds,
    input logic               out_valid,
    input logic               out_ready,
    input logic [13:0]        out_year,
    input logic [3:0]         out_month,
    input logic [4:0]         out_day,
    input logic [4:0]         out_hour,
    input logic [5:0]         out_minute,
    input logic [5:0]         out_second,
    input logic               range_error
);

    // stalled result beat holds its date, second and range_error fields
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
            && $stable(out_day) && $stable(out_second) && $stable(range_error))
        else $error("stalled result beat changed");

    // busy for the cycle after an input beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while converting");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> out_year == 14'd0 && out_month == 4'd0 && out_day == 5'd0)
        else $error("date fields not cleared on range error");

    a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !range_error |-> out_month >= 4'd1 && out_month <= 4'd12
            && out_day >= 5'd1 && out_year <= 14'd9999)
        else $error("date out of range");

    a_time_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59)
        else $error("time of day out of range");

endmodule

bind day_of_year_to_calendar_datetime dtc_checker u_dtc_checker (.*);
